// ----- design/tlvfp_pkg.sv -----
package tlvfp_pkg;

  // frame and tlv limits
  localparam int unsigned MAX_TLV_COUNT     = 16;
  localparam int unsigned MAX_PAYLOAD_BYTES = 255;

  // register file
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 3;
  localparam logic [7:0]  START_BYTE_RESET = 8'hAA;

  // crc-16/ccitt, msb first
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // byte roles within the tlv walk
  localparam logic [1:0] ROLE_TYPE   = 2'd0;
  localparam logic [1:0] ROLE_LEN    = 2'd1;
  localparam logic [1:0] ROLE_VALUE  = 2'd2;
  localparam logic [1:0] ROLE_BEYOND = 2'd3;

  // frame status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC       = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  // result word kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // one result word
  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [1:0] byte_role;
    logic [3:0] tlv_index;
    logic [7:0] value_position;
    logic [7:0] tlv_type;
    logic [7:0] seq_number;
    logic [7:0] payload_length;
    logic [4:0] tlv_count;
    logic [1:0] status;
  } result_t;

  // apb request toward the register file
  typedef struct packed {
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
  } apb_req_t;

  // crc update over one byte, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/tlvfp_in_if.sv -----
interface tlvfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/tlvfp_out_if.sv -----
interface tlvfp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic [1:0] byte_role;
  logic [3:0] tlv_index;
  logic [7:0] value_position;
  logic [7:0] tlv_type;
  logic [7:0] seq_number;
  logic [7:0] payload_length;
  logic [4:0] tlv_count;
  logic [1:0] status;

  modport source (
    output valid, output kind, output byte_value, output byte_role, output tlv_index,
    output value_position, output tlv_type, output seq_number, output payload_length,
    output tlv_count, output status, input ready
  );
  modport sink (
    input valid, input kind, input byte_value, input byte_role, input tlv_index,
    input value_position, input tlv_type, input seq_number, input payload_length,
    input tlv_count, input status, output ready
  );
endinterface

// ----- design/tlvfp_apb_regs.sv -----
module tlvfp_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tlvfp_pkg::apb_req_t                req_i,
  output logic [tlvfp_pkg::APB_DATA_W-1:0]   prdata_o,
  output logic                               pready_o,
  output logic [7:0]                         start_byte_o
);

  logic [7:0] start_byte_q;
  logic [7:0] start_byte_d;
  logic       hit_start;

  // word zero holds the start byte, higher words read as zero
  assign hit_start = (req_i.paddr[tlvfp_pkg::APB_ADDR_W-1:2] == '0);

  // write on the access phase
  always_comb begin
    start_byte_d = start_byte_q;
    if (req_i.psel && req_i.penable && req_i.pwrite && hit_start) begin
      start_byte_d = req_i.pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= tlvfp_pkg::START_BYTE_RESET;
    end else begin
      start_byte_q <= start_byte_d;
    end
  end

  // read back
  assign prdata_o     = hit_start ? {(tlvfp_pkg::APB_DATA_W - 8)'(0), start_byte_q} : '0;
  assign pready_o     = 1'b1;
  assign start_byte_o = start_byte_q;

endmodule

// ----- design/tlv_frame_parser_crc16_unit.sv -----
// TLV frame parser with CRC-16/CCITT check.
// in_i takes the received buffer one byte per word, last_byte marking the
// final byte. A frame is start byte, sequence, length, payload and a CRC-16
// (init 0xFFFF, poly 0x1021) sent low byte first, over sequence, length
// and payload. Each payload byte leaves on out_o as a payload word tagged
// with its tlv role, index, type and value position; the last byte of the
// buffer yields one status word instead (ok, crc mismatch or malformed) and
// the parser returns to its idle frame state.
// Results are registered and appear in the cycle after their byte is
// accepted. One byte is taken every cycle: the per-byte crc update and tlv
// tracking sit between the state registers and the result register.
// in_i.ready drops only while a result waits and out_o.ready is low; the
// waiting word then holds until taken. Reset clears the frame state and
// sets the start byte register to 0xAA. The user must write the APB port
// (start byte at address 0) only while idle; the unit does not enforce it.
module tlv_frame_parser_crc16_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tlvfp_in_if.sink                         in_i,
  tlvfp_out_if.source                      out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tlvfp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tlvfp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tlvfp_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  // frame phases
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_SEQ     = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC_LO  = 3'd4;
  localparam logic [2:0] PH_CRC_HI  = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_SKIP    = 3'd7;

  // error flag bits
  localparam int unsigned ERR_FRAME = 0;
  localparam int unsigned ERR_CRC   = 1;
  localparam int unsigned ERR_TLV   = 2;

  tlvfp_pkg::apb_req_t apb_req;
  logic [7:0]          start_byte;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  rem_q, rem_d;
  logic [1:0]  role_q, role_d;
  logic [7:0]  ctype_q, ctype_d;
  logic [7:0]  vpos_q, vpos_d;
  logic [2:0]  err_q, err_d;

  logic        accept;
  logic        in_ready;
  logic        emit;
  logic        produce;
  logic [1:0]  role_cur;
  logic [3:0]  o_idx;
  logic [7:0]  o_pos;
  logic [7:0]  o_typ;
  logic [7:0]  seen_new;
  logic [7:0]  rem_new;
  logic [1:0]  st;
  logic [7:0]  b;

  tlvfp_pkg::result_t res_d, res_q;
  logic               out_valid_q, out_valid_d;

  // register file
  assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite, paddr: paddr,
                     pwdata: pwdata};

  tlvfp_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (apb_req),
    .prdata_o    (prdata),
    .pready_o    (pready),
    .start_byte_o(start_byte)
  );

  // take a byte whenever the result register is free or draining
  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign b          = in_i.data_byte;

  // frame walk for one byte
  always_comb begin
    phase_d  = phase_q;
    seen_d   = seen_q;
    seq_d    = seq_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    role_d   = role_q;
    ctype_d  = ctype_q;
    vpos_d   = vpos_q;
    err_d    = err_q;
    emit     = 1'b0;
    role_cur = role_q;
    o_idx    = '0;
    o_pos    = '0;
    o_typ    = '0;
    seen_new = seen_q + 8'd1;
    rem_new  = rem_q - 8'd1;

    unique case (phase_q)
      PH_START: begin
        if (b == start_byte) begin
          phase_d = PH_SEQ;
        end else begin
          err_d[ERR_FRAME] = 1'b1;
          phase_d          = PH_SKIP;
        end
      end
      PH_SEQ: begin
        seq_d   = b;
        crc_d   = tlvfp_pkg::crc16_byte(crc_q, b);
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = b;
        crc_d = tlvfp_pkg::crc16_byte(crc_q, b);
        if ({1'b0, b} > 9'(tlvfp_pkg::MAX_PAYLOAD_BYTES)) begin
          err_d[ERR_FRAME] = 1'b1;
          phase_d          = PH_SKIP;
        end else begin
          phase_d = (b != 8'd0) ? PH_PAYLOAD : PH_CRC_LO;
        end
      end
      PH_PAYLOAD: begin
        crc_d  = tlvfp_pkg::crc16_byte(crc_q, b);
        seen_d = seen_new;
        emit   = 1'b1;
        // tlv limit reached: rest of payload is beyond the walk
        if (role_q == tlvfp_pkg::ROLE_TYPE && cnt_q >= 5'(tlvfp_pkg::MAX_TLV_COUNT)) begin
          role_cur = tlvfp_pkg::ROLE_BEYOND;
        end
        role_d = role_cur;
        unique case (role_cur)
          tlvfp_pkg::ROLE_TYPE: begin
            o_idx   = cnt_q[3:0];
            o_typ   = b;
            ctype_d = b;
            role_d  = tlvfp_pkg::ROLE_LEN;
          end
          tlvfp_pkg::ROLE_LEN: begin
            o_idx = cnt_q[3:0];
            o_typ = ctype_q;
            if (b > (len_q - seen_new)) begin
              err_d[ERR_TLV] = 1'b1;
            end
            rem_d  = b;
            vpos_d = '0;
            if (b == 8'd0) begin
              cnt_d  = cnt_q + 5'd1;
              role_d = tlvfp_pkg::ROLE_TYPE;
            end else begin
              role_d = tlvfp_pkg::ROLE_VALUE;
            end
          end
          tlvfp_pkg::ROLE_VALUE: begin
            o_idx  = cnt_q[3:0];
            o_typ  = ctype_q;
            o_pos  = vpos_q;
            vpos_d = vpos_q + 8'd1;
            rem_d  = rem_new;
            if (rem_new == 8'd0) begin
              cnt_d  = cnt_q + 5'd1;
              role_d = tlvfp_pkg::ROLE_TYPE;
            end
          end
          default: begin
          end
        endcase
        // payload end: a dangling type byte is a bad walk
        if (seen_new == len_q) begin
          if (role_d == tlvfp_pkg::ROLE_LEN) begin
            err_d[ERR_TLV] = 1'b1;
          end
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_d = b;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        if ({b, crc_lo_q} != crc_q) begin
          err_d[ERR_CRC] = 1'b1;
        end
        phase_d = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // status with precedence: framing, crc, tlv walk
  always_comb begin
    priority if (err_d[ERR_FRAME] || phase_d != PH_DONE) begin
      st = tlvfp_pkg::STATUS_MALFORMED;
    end else if (err_d[ERR_CRC]) begin
      st = tlvfp_pkg::STATUS_CRC;
    end else if (err_d[ERR_TLV]) begin
      st = tlvfp_pkg::STATUS_MALFORMED;
    end else begin
      st = tlvfp_pkg::STATUS_OK;
    end
  end

  // result word
  always_comb begin
    res_d = '0;
    if (in_i.last_byte) begin
      res_d.kind           = tlvfp_pkg::KIND_STATUS;
      res_d.seq_number     = seq_d;
      res_d.payload_length = len_d;
      res_d.tlv_count      = (st == tlvfp_pkg::STATUS_OK) ? cnt_d : '0;
      res_d.status         = st;
    end else begin
      res_d.kind           = tlvfp_pkg::KIND_PAYLOAD;
      res_d.byte_value     = b;
      res_d.byte_role      = role_cur;
      res_d.tlv_index      = o_idx;
      res_d.value_position = o_pos;
      res_d.tlv_type       = o_typ;
    end
  end

  assign produce = accept && (in_i.last_byte || emit);

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_ready) begin
      out_valid_d = produce;
    end
  end

  // frame state, cleared after the buffer's last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      seen_q   <= '0;
      seq_q    <= '0;
      len_q    <= '0;
      crc_q    <= tlvfp_pkg::CRC_INIT;
      crc_lo_q <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
      role_q   <= tlvfp_pkg::ROLE_TYPE;
      ctype_q  <= '0;
      vpos_q   <= '0;
      err_q    <= '0;
    end else if (accept) begin
      if (in_i.last_byte) begin
        phase_q  <= PH_START;
        seen_q   <= '0;
        seq_q    <= '0;
        len_q    <= '0;
        crc_q    <= tlvfp_pkg::CRC_INIT;
        crc_lo_q <= '0;
        cnt_q    <= '0;
        rem_q    <= '0;
        role_q   <= tlvfp_pkg::ROLE_TYPE;
        ctype_q  <= '0;
        vpos_q   <= '0;
        err_q    <= '0;
      end else begin
        phase_q  <= phase_d;
        seen_q   <= seen_d;
        seq_q    <= seq_d;
        len_q    <= len_d;
        crc_q    <= crc_d;
        crc_lo_q <= crc_lo_d;
        cnt_q    <= cnt_d;
        rem_q    <= rem_d;
        role_q   <= role_d;
        ctype_q  <= ctype_d;
        vpos_q   <= vpos_d;
        err_q    <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      res_q <= res_d;
    end
  end

  // output channel
  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.byte_value     = res_q.byte_value;
  assign out_o.byte_role      = res_q.byte_role;
  assign out_o.tlv_index      = res_q.tlv_index;
  assign out_o.value_position = res_q.value_position;
  assign out_o.tlv_type       = res_q.tlv_type;
  assign out_o.seq_number     = res_q.seq_number;
  assign out_o.payload_length = res_q.payload_length;
  assign out_o.tlv_count      = res_q.tlv_count;
  assign out_o.status         = res_q.status;

endmodule
